// File: rtl/core/lei_pkg.sv
// Shared types, constants and saturating helpers for the Lorenz Euler integrator.
// Used by lei_ctrl, lei_datapath and the top level; no dependencies.
package lei_pkg;

  localparam int DATA_W        = 32;
  localparam int DT_W          = 21;
  localparam int CNT_W         = 21;
  localparam int IDX_W         = 3;
  localparam int FRAC_BITS_DEF = 20;
  localparam int RUN_LEN_RST   = 100000;

  typedef enum logic [IDX_W-1:0] {
    REG_SIGMA   = 3'd0,
    REG_BETA    = 3'd1,
    REG_RHO     = 3'd2,
    REG_DT      = 3'd3,
    REG_START_X = 3'd4,
    REG_START_Y = 3'd5,
    REG_START_Z = 3'd6,
    REG_RUN_LEN = 3'd7
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_FIN
  } state_t;

  // operand pair fed to the shared multiplier
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_XY,
    MUL_SIG_T1,
    MUL_X_T2,
    MUL_BETA_Z,
    MUL_DT_DX,
    MUL_DT_DY,
    MUL_DT_DZ
  } mul_sel_t;

  // what is done with the rounded product registered by the previous multiply
  typedef enum logic [2:0] {
    WB_NONE,
    WB_DZ_XY,
    WB_DX,
    WB_DY,
    WB_DZ_SUB,
    WB_X,
    WB_Y,
    WB_Z
  } wb_sel_t;

  typedef struct packed {
    logic     load;
    logic     prep;
    mul_sel_t mul_sel;
    wb_sel_t  wb_sel;
  } cmd_t;

  typedef struct packed {
    logic slot_busy;
  } stat_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] max_v;
    logic signed [63:0] min_v;
    max_v = 64'sh0000_0000_7FFF_FFFF;
    min_v = -64'sh0000_0000_8000_0000;
    if (v > max_v) begin
      return 32'sh7FFF_FFFF;
    end else if (v < min_v) begin
      return 32'sh8000_0000;
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return s[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return s[DATA_W-1:0];
  endfunction

endpackage

// File: rtl/core/lei_ctrl.sv
// Sequencer for one Euler step: schedules the shared multiplier and write-backs.
// Depends on lei_pkg; drives lei_datapath through cmd_t, reads stat_t.
module lei_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lei_pkg::stat_t stat,
  output lei_pkg::cmd_t  cmd
);
  import lei_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.prep    = 1'b0;
    cmd.mul_sel = MUL_NONE;
    cmd.wb_sel  = WB_NONE;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep    = 1'b1;
        cmd.mul_sel = MUL_XY;
        state_next  = ST_M1;
      end
      ST_M1: begin
        cmd.mul_sel = MUL_SIG_T1;
        cmd.wb_sel  = WB_DZ_XY;
        state_next  = ST_M2;
      end
      ST_M2: begin
        cmd.mul_sel = MUL_X_T2;
        cmd.wb_sel  = WB_DX;
        state_next  = ST_M3;
      end
      ST_M3: begin
        cmd.mul_sel = MUL_BETA_Z;
        cmd.wb_sel  = WB_DY;
        state_next  = ST_M4;
      end
      ST_M4: begin
        cmd.mul_sel = MUL_DT_DX;
        cmd.wb_sel  = WB_DZ_SUB;
        state_next  = ST_M5;
      end
      ST_M5: begin
        cmd.mul_sel = MUL_DT_DY;
        cmd.wb_sel  = WB_X;
        state_next  = ST_M6;
      end
      ST_M6: begin
        cmd.mul_sel = MUL_DT_DZ;
        cmd.wb_sel  = WB_Y;
        state_next  = ST_FIN;
      end
      ST_FIN: begin
        // hold the final z update until the output slot is free
        if (!stat.slot_busy) begin
          cmd.wb_sel = WB_Z;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/lei_datapath.sv
// Datapath: config registers, point state, shared 32x32 multiplier with
// round/saturate stage, step counter and output register. Depends on lei_pkg.
module lei_datapath #(
  parameter int FRAC_BITS = lei_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [lei_pkg::IDX_W-1:0]          wr_index,
  input  logic [lei_pkg::DATA_W-1:0]         wr_data,
  input  logic                               restart,
  input  lei_pkg::cmd_t                      cmd,
  output lei_pkg::stat_t                     stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [lei_pkg::DATA_W-1:0]  pos_x,
  output logic signed [lei_pkg::DATA_W-1:0]  pos_y,
  output logic signed [lei_pkg::DATA_W-1:0]  pos_z,
  output logic                               last_point
);
  import lei_pkg::*;

  localparam logic signed [63:0] ONE      = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF     = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [DATA_W-1:0] SIGMA_RST = sat32(64'sd10 * ONE);
  localparam logic signed [DATA_W-1:0] BETA_RST  = sat32((64'sd8 * ONE + 64'sd1) / 64'sd3);
  localparam logic signed [DATA_W-1:0] RHO_RST   = sat32(64'sd28 * ONE);
  localparam logic signed [DATA_W-1:0] START_RST = sat32(ONE);
  localparam logic signed [63:0]       DT_FULL   = (ONE + 64'sd500) / 64'sd1000;
  localparam logic [DT_W-1:0]          DT_RST    = DT_FULL[DT_W-1:0];
  localparam logic [CNT_W-1:0]         RUN_RST   = CNT_W'(RUN_LEN_RST);

  // configuration
  logic signed [DATA_W-1:0] sigma_gain, beta_gain, rho_gain;
  logic signed [DATA_W-1:0] start_x, start_y, start_z;
  logic [DT_W-1:0]          time_step;
  logic [CNT_W-1:0]         run_length;

  // state
  logic signed [DATA_W-1:0] cur_x, cur_y, cur_z;
  logic [CNT_W-1:0]         step_count;

  // scratch
  logic signed [DATA_W-1:0] t1, t2, dx, dy, dz;
  logic signed [63:0]       prod;

  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [63:0]       prod_rnd;
  logic signed [63:0]       prod_shr;
  logic signed [DATA_W-1:0] rnd;
  logic signed [DATA_W-1:0] z_new;
  logic [CNT_W-1:0]         cnt_inc;
  logic                     is_last;
  logic                     new_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma_gain <= SIGMA_RST;
      beta_gain  <= BETA_RST;
      rho_gain   <= RHO_RST;
      time_step  <= DT_RST;
      start_x    <= START_RST;
      start_y    <= START_RST;
      start_z    <= START_RST;
      run_length <= RUN_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_SIGMA:   sigma_gain <= wr_data;
        REG_BETA:    beta_gain  <= wr_data;
        REG_RHO:     rho_gain   <= wr_data;
        REG_DT:      time_step  <= wr_data[DT_W-1:0];
        REG_START_X: start_x    <= wr_data;
        REG_START_Y: start_y    <= wr_data;
        REG_START_Z: start_z    <= wr_data;
        REG_RUN_LEN: run_length <= wr_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_XY: begin
        mul_a = cur_x;
        mul_b = cur_y;
      end
      MUL_SIG_T1: begin
        mul_a = sigma_gain;
        mul_b = t1;
      end
      MUL_X_T2: begin
        mul_a = cur_x;
        mul_b = t2;
      end
      MUL_BETA_Z: begin
        mul_a = beta_gain;
        mul_b = cur_z;
      end
      MUL_DT_DX: begin
        mul_a = $signed({{(DATA_W-DT_W){1'b0}}, time_step});
        mul_b = dx;
      end
      MUL_DT_DY: begin
        mul_a = $signed({{(DATA_W-DT_W){1'b0}}, time_step});
        mul_b = dy;
      end
      MUL_DT_DZ: begin
        mul_a = $signed({{(DATA_W-DT_W){1'b0}}, time_step});
        mul_b = dz;
      end
      default: ;
    endcase
  end

  // round to nearest, ties up: add half an lsb, then floor shift
  assign prod_rnd = prod + HALF;
  assign prod_shr = prod_rnd >>> FRAC_BITS;
  assign rnd      = sat32(prod_shr);
  assign z_new    = sat_add(cur_z, rnd);

  assign cnt_inc  = step_count + CNT_W'(1);
  assign is_last  = (cnt_inc >= run_length);
  assign new_run  = restart || (step_count == '0);

  assign stat.slot_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.prep) begin
      t1 <= sat_sub(cur_y, cur_x);
      t2 <= sat_sub(rho_gain, cur_z);
    end
    case (cmd.wb_sel)
      WB_DZ_XY:  dz <= rnd;
      WB_DX:     dx <= rnd;
      WB_DY:     dy <= sat_sub(rnd, cur_y);
      WB_DZ_SUB: dz <= sat_sub(dz, rnd);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= START_RST;
      cur_y      <= START_RST;
      cur_z      <= START_RST;
      step_count <= '0;
    end else if (cmd.load) begin
      if (new_run) begin
        cur_x      <= start_x;
        cur_y      <= start_y;
        cur_z      <= start_z;
        step_count <= '0;
      end
    end else begin
      case (cmd.wb_sel)
        WB_X: cur_x <= sat_add(cur_x, rnd);
        WB_Y: cur_y <= sat_add(cur_y, rnd);
        WB_Z: begin
          cur_z      <= z_new;
          step_count <= is_last ? '0 : cnt_inc;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.wb_sel == WB_Z) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb_sel == WB_Z) begin
      pos_x      <= cur_x;
      pos_y      <= cur_y;
      pos_z      <= z_new;
      last_point <= is_last;
    end
  end

endmodule

// File: rtl/core/lorenz_euler_integrator_core.sv
// A request runs PREP, M1 to M6 and FIN; FIN writes the result to the output register
// when it is free. Requests are taken only in IDLE; the seven products of a step go
// one by one through a single shared 32x32 multiplier and its round/saturate stage.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active high) loads the default coefficients and start point,
// clears the step count and empties the output register.
module lorenz_euler_integrator_core #(
  parameter int FRAC_BITS = lei_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [lei_pkg::IDX_W-1:0]          wr_index,
  input  logic [lei_pkg::DATA_W-1:0]         wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               restart,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [lei_pkg::DATA_W-1:0]  pos_x,
  output logic signed [lei_pkg::DATA_W-1:0]  pos_y,
  output logic signed [lei_pkg::DATA_W-1:0]  pos_z,
  output logic                               last_point
);
  import lei_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lei_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lei_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .restart    (restart),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .last_point (last_point)
  );

  // the final commit never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.wb_sel == WB_Z |-> !(out_valid && !out_ready))
    else $error("result committed over a pending one");

  // once a request is taken the sequencer is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accepting a request");

  // a result only appears at the end of a running step
  a_result_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a step in progress");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for lorenz_euler_integrator_core: one Euler step per request,
// checked against a fixed-point Lorenz predictor. Depends on lei_pkg and the core.
module tb_top;
  import lei_pkg::*;

  localparam int FRAC         = FRAC_BITS_DEF;
  localparam int RANDOM_ITEMS = 1930;
  localparam int QUIET_FROM   = 1650;
  localparam int HOLD_CYCLES  = 320;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PRINT_LIMIT  = 40;

  typedef logic signed [DATA_W-1:0] q_t;

  typedef struct packed {
    q_t   x;
    q_t   y;
    q_t   z;
    logic last;
  } point_t;

  typedef enum logic {ROW_WRITE, ROW_STEP} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    reg_index_t idx;
    logic [31:0] data;
    bit         rs;
    bit         typed;
    point_t     want;
  } stim_row_t;

  localparam q_t Q_HI  = 32'sh7FFF_FFFF;
  localparam q_t Q_LO  = 32'sh8000_0000;
  localparam q_t Q_ONE = 32'sh0010_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [IDX_W-1:0] wr_index = '0;
  logic [DATA_W-1:0] wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] pos_x, pos_y, pos_z;
  logic last_point;

  lorenz_euler_integrator_core uut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .last_point (last_point)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of the coefficients and trajectory, reset values
  q_t cfg_sigma = 32'sd10485760;
  q_t cfg_beta  = 32'sd2796203;
  q_t cfg_rho   = 32'sd29360128;
  logic [DT_W-1:0]  cfg_dt      = 21'd1049;
  q_t cfg_sx = Q_ONE;
  q_t cfg_sy = Q_ONE;
  q_t cfg_sz = Q_ONE;
  logic [CNT_W-1:0] cfg_run_len = 21'd100000;
  q_t cur_x = Q_ONE;
  q_t cur_y = Q_ONE;
  q_t cur_z = Q_ONE;
  logic [CNT_W-1:0] steps_done = '0;

  point_t    pending_points[$];
  stim_row_t directed_rows[$];
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  random_sent = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;

  function automatic q_t clamp32(input longint v);
    if (v > 64'sd2147483647) return Q_HI;
    if (v < -64'sd2147483648) return Q_LO;
    return v[31:0];
  endfunction

  // product rounded to nearest, ties upward, then saturated
  function automatic q_t qmul(input longint a, input longint b);
    longint p;
    p = a * b + (longint'(1) <<< (FRAC - 1));
    return clamp32(p >>> FRAC);
  endfunction

  function automatic void lorenz_step(input bit rs, output point_t nxt);
    q_t dx, dy, dz;
    if (rs || steps_done == 0) begin
      cur_x = cfg_sx;
      cur_y = cfg_sy;
      cur_z = cfg_sz;
      steps_done = '0;
    end
    dx = qmul(cfg_sigma, clamp32(longint'(cur_y) - longint'(cur_x)));
    dy = clamp32(longint'(qmul(cur_x, clamp32(longint'(cfg_rho) - longint'(cur_z))))
                 - longint'(cur_y));
    dz = clamp32(longint'(qmul(cur_x, cur_y)) - longint'(qmul(cfg_beta, cur_z)));
    cur_x = clamp32(longint'(cur_x) + longint'(qmul(cfg_dt, dx)));
    cur_y = clamp32(longint'(cur_y) + longint'(qmul(cfg_dt, dy)));
    cur_z = clamp32(longint'(cur_z) + longint'(qmul(cfg_dt, dz)));
    steps_done = steps_done + 1'b1;
    nxt.x = cur_x;
    nxt.y = cur_y;
    nxt.z = cur_z;
    nxt.last = (steps_done >= cfg_run_len);
    if (nxt.last) steps_done = '0;
  endfunction

  function automatic void apply_reg(input reg_index_t idx, input logic [31:0] data);
    case (idx)
      REG_SIGMA:   cfg_sigma = data;
      REG_BETA:    cfg_beta = data;
      REG_RHO:     cfg_rho = data;
      REG_DT:      cfg_dt = data[DT_W-1:0];
      REG_START_X: cfg_sx = data;
      REG_START_Y: cfg_sy = data;
      REG_START_Z: cfg_sz = data;
      REG_RUN_LEN: cfg_run_len = data[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void add_write(input reg_index_t idx, input logic [31:0] data);
    stim_row_t r;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    r.rs = 1'b0;
    r.typed = 1'b0;
    r.want = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_step(input bit rs, input bit typed, input q_t x, input q_t y,
                                   input q_t z, input bit last);
    stim_row_t r;
    r.kind = ROW_STEP;
    r.idx = REG_SIGMA;
    r.data = '0;
    r.rs = rs;
    r.typed = typed;
    r.want = '{x: x, y: y, z: z, last: last};
    directed_rows.push_back(r);
  endfunction

  function automatic logic [31:0] pick_q(input bit coef);
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = $urandom();
      1: v = 32'h7FFF_FFFF;
      2: v = 32'h8000_0000;
      3: v = '0;
      default: v = coef ? $urandom_range(0, 48 << 20)
                        : $urandom_range(0, 64 << 20) - (32 << 20);
    endcase
    return v;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t: %s expected %h got %h", $time, what, want, got);
    mismatch_count++;
  endtask

  // holds the request until taken; the predictor advances at acceptance
  task automatic push_request(input bit rs, input bit typed, input point_t want);
    point_t pred;
    in_valid <= 1'b1;
    restart <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lorenz_step(rs, pred);
    pending_points.push_back(typed ? want : pred);
  endtask

  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      restart <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(input reg_index_t idx, input logic [31:0] data);
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    apply_reg(idx, data);
    @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    point_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        flag_mismatch("result with no request outstanding", '0, pos_x);
      end else begin
        want = pending_points.pop_front();
        if (pos_x !== want.x) flag_mismatch("pos_x", want.x, pos_x);
        if (pos_y !== want.y) flag_mismatch("pos_y", want.y, pos_y);
        if (pos_z !== want.z) flag_mismatch("pos_z", want.z, pos_z);
        if (last_point !== want.last)
          flag_mismatch("last_point", 32'(want.last), 32'(last_point));
      end
    end
  end

  // sink side: random stalls, one long hold-off so the core backs up
  initial begin : sink_ctrl
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[lorenz_euler_integrator_core] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    reg_index_t  idx;
    logic [31:0] val;
    int          phase_len;
    bit          no_gaps;

    // defaults after reset, then a restart
    add_step(1'b0, 1'b0, 0, 0, 0, 1'b0);
    add_step(1'b0, 1'b0, 0, 0, 0, 1'b0);
    add_step(1'b1, 1'b0, 0, 0, 0, 1'b0);
    // zero time step holds the start point; zero run length flags every point
    add_write(REG_DT, 32'h0000_0000);
    add_write(REG_RUN_LEN, 32'h0000_0000);
    add_step(1'b1, 1'b1, Q_ONE, Q_ONE, Q_ONE, 1'b1);
    add_write(REG_START_X, Q_HI);
    add_write(REG_START_Y, Q_LO);
    add_write(REG_START_Z, Q_HI);
    add_step(1'b0, 1'b1, Q_HI, Q_LO, Q_HI, 1'b1);
    add_write(REG_START_X, Q_LO);
    add_write(REG_START_Y, Q_HI);
    add_write(REG_START_Z, Q_LO);
    add_step(1'b1, 1'b1, Q_LO, Q_HI, Q_LO, 1'b1);
    // extreme coefficients, largest time step, upper data bits ignored
    add_write(REG_SIGMA, Q_HI);
    add_write(REG_BETA, Q_LO);
    add_write(REG_RHO, Q_LO);
    add_write(REG_DT, 32'hFFFF_FFFF);
    add_write(REG_RUN_LEN, 32'hFFE0_0003);
    repeat (4) add_step(1'b0, 1'b0, 0, 0, 0, 1'b0);
    // origin is a fixed point whatever the coefficients
    add_write(REG_START_X, 32'h0);
    add_write(REG_START_Y, 32'h0);
    add_write(REG_START_Z, 32'h0);
    add_write(REG_DT, 32'h0010_0000);
    add_step(1'b1, 1'b1, 0, 0, 0, 1'b0);
    add_step(1'b0, 1'b1, 0, 0, 0, 1'b0);
    add_step(1'b0, 1'b1, 0, 0, 0, 1'b1);
    // new start point mid-run only counts from the next run
    add_write(REG_RUN_LEN, 32'hFFFF_FFFF);
    add_write(REG_SIGMA, 32'hFF60_0000);
    add_write(REG_BETA, 32'h0010_0000);
    add_write(REG_RHO, 32'h0000_0000);
    add_write(REG_DT, 32'd1049);
    add_write(REG_START_X, 32'hFFF0_0000);
    add_write(REG_START_Y, 32'h0020_0000);
    add_write(REG_START_Z, 32'h0008_0000);
    add_step(1'b1, 1'b0, 0, 0, 0, 1'b0);
    add_step(1'b0, 1'b0, 0, 0, 0, 1'b0);
    add_write(REG_START_X, 32'h0030_0000);
    add_step(1'b0, 1'b0, 0, 0, 0, 1'b0);
    add_step(1'b1, 1'b0, 0, 0, 0, 1'b0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        push_request(directed_rows[i].rs, directed_rows[i].typed, directed_rows[i].want);
        idle_gap();
      end
    end

    while (random_sent < RANDOM_ITEMS) begin
      for (int r = 0; r < 8; r++) begin
        if ($urandom_range(0, 3) != 0) begin
          idx = reg_index_t'(r);
          case (idx)
            REG_DT: begin
              case ($urandom_range(0, 5))
                0: val = '0;
                1: val = 32'h001F_FFFF;
                2: val = 32'h0010_0000;
                default: val = $urandom_range(1, 16384);
              endcase
              val = val | ($urandom() & 32'hFFE0_0000);
            end
            REG_RUN_LEN: begin
              case ($urandom_range(0, 7))
                0: val = '0;
                1: val = 32'h001F_FFFF;
                2: val = 32'h0010_0000;
                default: val = $urandom_range(1, 40);
              endcase
              val = val | ($urandom() & 32'hFFE0_0000);
            end
            REG_START_X, REG_START_Y, REG_START_Z: val = pick_q(1'b0);
            default: val = pick_q(1'b1);
          endcase
          write_reg(idx, val);
        end
      end
      no_gaps = 1'b0;
      phase_len = $urandom_range(10, 90);
      if (!hold_req && random_sent >= 400) begin
        hold_req = 1'b1;
        no_gaps = 1'b1;
        phase_len = 40;
      end
      repeat (phase_len) begin
        push_request($urandom_range(0, 19) == 0, 1'b0, '0);
        random_sent++;
        if (random_sent >= QUIET_FROM) quiet = 1'b1;
        if (!no_gaps) idle_gap();
      end
    end

    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[lorenz_euler_integrator_core] OK");
    end else begin
      $display("[lorenz_euler_integrator_core] ERROR");
    end
    $finish;
  end

endmodule
